// ----- sv/fse_pkg.sv -----
package fse_pkg;

  // argument path width default and magnitude datapath
  localparam int ARG_BITS_DEF = 32;
  localparam int ARG_PORT_W   = 32;
  localparam int MAG_BITS     = 32;
  localparam int PROD_W       = 2 * MAG_BITS;
  localparam int DIG_MAX      = 10;
  localparam int CNT_W        = $clog2(DIG_MAX + 1);
  localparam int DIG_IDX_W    = $clog2(DIG_MAX);

  // divide by ten through a constant reciprocal
  localparam logic [MAG_BITS-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                  RECIP_SHIFT = 35;

  // character codes
  localparam logic [7:0] INSERT_RST = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_A_LOW   = 8'h61;

  // action codes
  localparam logic ACT_FORMAT = 1'b0;
  localparam logic ACT_ARG    = 1'b1;

  // awaited argument kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_CHAR = 3'd1;
  localparam logic [2:0] KIND_SDEC = 3'd2;
  localparam logic [2:0] KIND_UDEC = 3'd3;
  localparam logic [2:0] KIND_HEX2 = 3'd4;
  localparam logic [2:0] KIND_HEX4 = 3'd5;
  localparam logic [2:0] KIND_HEX8 = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ARG_UNEXP = 2'd1;
  localparam logic [1:0] ST_FMT_WAIT  = 2'd2;

  // output character source select
  localparam logic [2:0] EM_ITEM  = 3'd0;
  localparam logic [2:0] EM_NONE  = 3'd1;
  localparam logic [2:0] EM_BYTE  = 3'd2;
  localparam logic [2:0] EM_MINUS = 3'd3;
  localparam logic [2:0] EM_DEC   = 3'd4;
  localparam logic [2:0] EM_HEX   = 3'd5;

  // digit counter operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_LOAD = 2'd1;
  localparam logic [1:0] CNT_INC  = 2'd2;
  localparam logic [1:0] CNT_DEC  = 2'd3;

  typedef struct packed {
    logic                  action;
    logic [7:0]            format_char;
    logic                  end_of_format;
    logic [ARG_PORT_W-1:0] argument;
  } fse_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic [1:0] status;
  } fse_out_t;

  // controller to datapath
  typedef struct packed {
    logic             load_item;
    logic             load_val;
    logic             load_signed;
    logic             mul;
    logic             div;
    logic [1:0]       cnt_op;
    logic [CNT_W-1:0] cnt_init;
    logic             emit;
    logic [2:0]       emit_sel;
    logic [1:0]       emit_status;
    logic             emit_last;
  } fse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       action;
    logic       eof;
    logic       is_insert;
    logic [2:0] spec_kind;
    logic       neg;
    logic       q_zero;
    logic       cnt_one;
    logic       cnt_zero;
    logic       slot_free;
  } fse_stat_t;

  function automatic logic [2:0] kind_of(input logic [7:0] spec);
    logic [2:0] k;
    begin
      case (spec)
        8'h63:        k = KIND_CHAR;
        8'h69, 8'h6C: k = KIND_SDEC;
        8'h75, 8'h55: k = KIND_UDEC;
        8'h62:        k = KIND_HEX2;
        8'h77:        k = KIND_HEX4;
        8'h64:        k = KIND_HEX8;
        default:      k = KIND_NONE;
      endcase
      return k;
    end
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] c;
    begin
      if (nib < 4'd10) begin
        c = CH_ZERO + {4'b0000, nib};
      end else begin
        c = 8'h41 + {4'b0000, nib - 4'd10};
      end
      return c;
    end
  endfunction

endpackage

// ----- sv/fse_ctrl.sv -----
module fse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fse_pkg::fse_stat_t stat,
  output fse_pkg::fse_cmd_t  cmd
);
  import fse_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_MUL     = 3'd2;
  localparam logic [2:0] S_DIV     = 3'd3;
  localparam logic [2:0] S_SIGN    = 3'd4;
  localparam logic [2:0] S_DEC_OUT = 3'd5;
  localparam logic [2:0] S_HEX     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       insert_seen_r, insert_seen_nxt;
  logic [2:0] awaited_r, awaited_nxt;

  assign in_ready = (state_r == S_IDLE);

  // sequencing and specifier tracking
  always_comb begin
    state_nxt       = state_r;
    insert_seen_nxt = insert_seen_r;
    awaited_nxt     = awaited_r;
    cmd             = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.emit_last = 1'b1;
        if (stat.action == ACT_FORMAT) begin
          if (awaited_r != KIND_NONE) begin
            // format character while an argument is pending
            cmd.emit_sel    = EM_NONE;
            cmd.emit_status = ST_FMT_WAIT;
            if (stat.slot_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else if (insert_seen_r) begin
            if (stat.spec_kind != KIND_NONE) begin
              awaited_nxt     = stat.spec_kind;
              insert_seen_nxt = 1'b0;
              state_nxt       = S_IDLE;
            end else begin
              cmd.emit_sel = EM_ITEM;
              if (stat.slot_free) begin
                cmd.emit        = 1'b1;
                insert_seen_nxt = 1'b0;
                state_nxt       = S_IDLE;
              end
            end
          end else if (stat.is_insert && !stat.eof) begin
            insert_seen_nxt = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.emit_sel = EM_ITEM;
            if (stat.slot_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end else begin
          case (awaited_r)
            KIND_NONE: begin
              cmd.emit_sel    = EM_NONE;
              cmd.emit_status = ST_ARG_UNEXP;
              if (stat.slot_free) begin
                cmd.emit  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            KIND_CHAR: begin
              cmd.emit_sel = EM_BYTE;
              if (stat.slot_free) begin
                cmd.emit    = 1'b1;
                awaited_nxt = KIND_NONE;
                state_nxt   = S_IDLE;
              end
            end
            KIND_SDEC, KIND_UDEC: begin
              cmd.load_val    = 1'b1;
              cmd.load_signed = (awaited_r == KIND_SDEC);
              cmd.cnt_op      = CNT_LOAD;
              cmd.cnt_init    = '0;
              awaited_nxt     = KIND_NONE;
              state_nxt       = S_MUL;
            end
            KIND_HEX2: begin
              cmd.load_val = 1'b1;
              cmd.cnt_op   = CNT_LOAD;
              cmd.cnt_init = CNT_W'(1);
              awaited_nxt  = KIND_NONE;
              state_nxt    = S_HEX;
            end
            KIND_HEX4: begin
              cmd.load_val = 1'b1;
              cmd.cnt_op   = CNT_LOAD;
              cmd.cnt_init = CNT_W'(3);
              awaited_nxt  = KIND_NONE;
              state_nxt    = S_HEX;
            end
            default: begin
              cmd.load_val = 1'b1;
              cmd.cnt_op   = CNT_LOAD;
              cmd.cnt_init = CNT_W'(7);
              awaited_nxt  = KIND_NONE;
              state_nxt    = S_HEX;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // push one decimal digit, low digit first
        cmd.div    = 1'b1;
        cmd.cnt_op = CNT_INC;
        if (stat.q_zero) begin
          state_nxt = stat.neg ? S_SIGN : S_DEC_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SIGN: begin
        cmd.emit_sel = EM_MINUS;
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_DEC_OUT;
        end
      end
      S_DEC_OUT: begin
        cmd.emit_sel  = EM_DEC;
        cmd.emit_last = stat.cnt_one;
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.cnt_op = CNT_DEC;
          if (stat.cnt_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_HEX: begin
        cmd.emit_sel  = EM_HEX;
        cmd.emit_last = stat.cnt_zero;
        if (stat.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.cnt_op = CNT_DEC;
          if (stat.cnt_zero) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      insert_seen_r <= 1'b0;
      awaited_r     <= KIND_NONE;
    end else begin
      state_r       <= state_nxt;
      insert_seen_r <= insert_seen_nxt;
      awaited_r     <= awaited_nxt;
    end
  end

endmodule

// ----- sv/fse_dp.sv -----
module fse_dp #(
  parameter int ARG_BITS = fse_pkg::ARG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fse_pkg::fse_in_t   in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fse_pkg::fse_out_t  out_data,
  input  fse_pkg::fse_cmd_t  cmd,
  output fse_pkg::fse_stat_t stat
);
  import fse_pkg::*;

  fse_in_t              item_r;
  logic [7:0]           insert_char_r;
  logic [MAG_BITS-1:0]  val_r;
  logic                 neg_r;
  logic [PROD_W-1:0]    prod_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [3:0]           dstk_r [DIG_MAX];
  logic                 out_valid_r;
  fse_out_t             out_item_r;

  logic [ARG_BITS-1:0]  arg_v;
  logic [ARG_BITS-1:0]  arg_neg;
  logic                 arg_is_neg;
  logic [MAG_BITS-1:0]  q_val;
  logic [MAG_BITS-1:0]  q_ten;
  logic [MAG_BITS-1:0]  rem_val;
  logic [DIG_IDX_W-1:0] rd_idx;
  logic [MAG_BITS-1:0]  hex_sh;
  logic [7:0]           emit_char;
  logic                 slot_free;

  assign cfg_ready = 1'b1;

  // argument view within the configured width
  assign arg_v      = ARG_BITS'(item_r.argument);
  assign arg_neg    = ~arg_v + 1'b1;
  assign arg_is_neg = cmd.load_signed & arg_v[ARG_BITS-1];

  // quotient and remainder of the current value by ten
  assign q_val   = MAG_BITS'(prod_r >> RECIP_SHIFT);
  assign q_ten   = (q_val << 3) + (q_val << 1);
  assign rem_val = val_r - q_ten;

  assign rd_idx = DIG_IDX_W'(cnt_r - 1'b1);
  assign hex_sh = val_r >> {cnt_r[2:0], 2'b00};

  assign slot_free = !out_valid_r || out_ready;

  // status to controller
  always_comb begin
    stat.action    = item_r.action;
    stat.eof       = item_r.end_of_format;
    stat.is_insert = (item_r.format_char == insert_char_r);
    stat.spec_kind = kind_of(item_r.format_char);
    stat.neg       = neg_r;
    stat.q_zero    = (q_val == '0);
    stat.cnt_one   = (cnt_r == CNT_W'(1));
    stat.cnt_zero  = (cnt_r == '0);
    stat.slot_free = slot_free;
  end

  // character selection
  always_comb begin
    case (cmd.emit_sel)
      EM_ITEM:  emit_char = item_r.format_char;
      EM_NONE:  emit_char = 8'h00;
      EM_BYTE:  emit_char = arg_v[7:0];
      EM_MINUS: emit_char = CH_MINUS;
      EM_DEC:   emit_char = CH_ZERO + {4'b0000, dstk_r[rd_idx]};
      EM_HEX:   emit_char = hex_ascii(hex_sh[3:0]);
      default:  emit_char = 8'h00;
    endcase
  end

  // insert character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insert_char_r <= INSERT_RST;
    end else if (cfg_valid) begin
      insert_char_r <= cfg_data;
    end
  end

  // item and value registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.load_val) begin
      val_r <= MAG_BITS'(arg_is_neg ? arg_neg : arg_v);
      neg_r <= arg_is_neg;
    end else if (cmd.div) begin
      val_r <= q_val;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(val_r) * PROD_W'(RECIP_TEN);
    end
    if (cmd.div) begin
      dstk_r[DIG_IDX_W'(cnt_r)] <= rem_val[3:0];
    end
  end

  // digit counter
  always_ff @(posedge clk) begin
    case (cmd.cnt_op)
      CNT_LOAD: cnt_r <= cmd.cnt_init;
      CNT_INC:  cnt_r <= cnt_r + 1'b1;
      CNT_DEC:  cnt_r <= cnt_r - 1'b1;
      default:  cnt_r <= cnt_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.out_char    <= emit_char;
      out_item_r.last_of_run <= cmd.emit_last;
      out_item_r.status      <= cmd.emit_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ----- sv/format_string_to_ascii_engine.sv -----
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    fse_in_t: action, format_char, end_of_format,
//                                             argument
// out_      output     out_valid / out_ready  fse_out_t: out_char, last_of_run, status
// cfg_      input      cfg_valid / cfg_ready  cfg_data: insert character
//
// a format character is taken in S_IDLE, then decoded and emitted in S_DECODE
// a c argument is emitted from S_DECODE; a hex argument emits its n digits from S_HEX, high digit first
// a decimal argument runs S_MUL and S_DIV for each digit, plus S_SIGN for a minus sign:
// the divide-by-ten step is a constant multiply then a subtract; S_DEC_OUT then sends the digits
// reset (synchronous, rst_n low) clears pending specifier state and sets the insert char to '#'
// a stalled output holds the result in its register; the engine waits, taking no new input
module format_string_to_ascii_engine #(
  parameter int ARG_BITS = fse_pkg::ARG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fse_pkg::fse_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fse_pkg::fse_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);
  import fse_pkg::*;

  fse_cmd_t  cmd;
  fse_stat_t stat;

  // sequencer
  fse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // data registers, digit conversion and output register
  fse_dp #(
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
